// ===== src/quaternion_nlerp_assert.svh =====
// Assertion macros for the quaternion blend pipeline.
// Each macro takes a label, a condition and a consequence, sampled on clk
// and ignored while rst_n is low.
`ifndef QUATERNION_NLERP_ASSERT_SVH
`define QUATERNION_NLERP_ASSERT_SVH

// Consequence holds in the same cycle
`define QNL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("quaternion_nlerp check failed");

// Consequence holds in the following cycle
`define QNL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("quaternion_nlerp check failed");

`endif

// ===== src/qnlerp_pkg.sv =====
package qnlerp_pkg;

    // Component format
    localparam int COMP_W    = 16;
    localparam int FRAC_BITS = 14;
    localparam int PROG_W    = 16;
    localparam logic [PROG_W-1:0] PROG_ONE = 16'd32768;

    // Widths along the datapath
    localparam int PROD_W = 32;             // component products
    localparam int BLEND_W = 33;            // signed blend component
    localparam int MAG_W = 32;              // blend magnitude
    localparam int NORM_W = 30;             // normalised magnitude, below 2^30
    localparam int NORM_TOP = NORM_W - 1;   // target msb position
    localparam int SQ_W = 2 * NORM_W;       // one square
    localparam int SUM_W = SQ_W + 2;        // sum of four squares
    localparam int ROOT_W = 64;             // square root working value
    localparam int LEN_W = 31;              // length, below 2^31
    localparam int NUM_W = NORM_W + FRAC_BITS + 1;
    localparam int QBITS = 16;              // quotient bits

    // Stage map
    localparam int ST_ISQ0 = 8;
    localparam int ISQ_STEPS = SUM_W / 2 + 1;
    localparam int ST_DIV0 = ST_ISQ0 + ISQ_STEPS + 1;
    localparam int ST_OUT = ST_DIV0 + QBITS + 1;
    localparam int NSTG = ST_OUT + 1;

    typedef logic [3:0][NORM_W-1:0] norm_vec_t;

    typedef struct packed {
        logic [3:0] sg;
        logic       neg;
        logic       zero;
    } meta_t;

endpackage

// ===== src/quaternion_nlerp.sv =====
// quaternion_nlerp: normalised blend of two quaternions along the shorter arc.
// Input channel s_axis_*: one transfer carries a and b (signed Q2.14) and the
// progress fraction (unsigned Q1.15, values above one are clamped to one).
// Output channel m_axis_*: one transfer per input transfer, in order, with the
// normalised blend (signed Q2.14, saturated) in tdata and two flags in tuser:
// flipped (b was negated because a.b < 0) and zero_length (blend vanished,
// components forced to zero).
// Throughput: one item per cycle while the receiver accepts results. The path is
// 59 register stages, set by the one-bit-per-stage square root (32 stages) and
// divider (16 stages).
// Each stage holds its own valid bit and moves on whenever the stage after it
// is empty or moving, so bubbles are squeezed out. When the receiver stalls,
// the output holds and the pipe keeps filling until it is full; only then is
// s_axis_tready dropped. Nothing is lost or repeated.
// Reset clears every valid bit; the block takes input on the first cycle
// after reset is released.
module quaternion_nlerp (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, progress (16 bits each)
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_w, out_x, out_y, out_z (16 bits each), zero fill to 72 bits
    output logic [71:0]  m_axis_tdata,
    // flipped, zero_length
    output logic [1:0]   m_axis_tuser
);

    localparam int N = qnlerp_pkg::NSTG;
    localparam int CW = qnlerp_pkg::COMP_W;

    logic [N-1:0] v_reg;
    logic [N-1:0] adv;

    // Advance a stage when it is empty or the one after it advances
    always_comb
    begin
        adv[N-1] = !v_reg[N-1] || m_axis_tready;
        for (int k = N - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    assign s_axis_tready = adv[0];

    // Valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < N; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: products ----------------
    logic signed [CW-1:0] a_in [4];
    logic signed [CW-1:0] b_in [4];
    logic [qnlerp_pkg::PROG_W-1:0] t_sat;
    logic [qnlerp_pkg::PROG_W-1:0] omt;
    logic signed [qnlerp_pkg::PROD_W-1:0] ab_next [4];
    logic signed [qnlerp_pkg::PROD_W-1:0] pa_next [4];
    logic signed [qnlerp_pkg::PROD_W-1:0] pb_next [4];
    logic signed [qnlerp_pkg::PROD_W-1:0] ab_reg [4];
    logic signed [qnlerp_pkg::PROD_W-1:0] pa_reg [4];
    logic signed [qnlerp_pkg::PROD_W-1:0] pb_reg [4];

    always_comb
    begin
        logic signed [qnlerp_pkg::PROD_W-1:0] ax;
        logic signed [qnlerp_pkg::PROD_W-1:0] bx;
        logic signed [qnlerp_pkg::PROD_W-1:0] tx;
        logic signed [qnlerp_pkg::PROD_W-1:0] ox;
        t_sat = (s_axis_tdata[143:128] > qnlerp_pkg::PROG_ONE) ? qnlerp_pkg::PROG_ONE
                                                                : s_axis_tdata[143:128];
        omt = qnlerp_pkg::PROG_ONE - t_sat;
        tx = qnlerp_pkg::PROD_W'(t_sat);
        ox = qnlerp_pkg::PROD_W'(omt);
        for (int i = 0; i < 4; i++)
        begin
            a_in[i] = s_axis_tdata[i*CW +: CW];
            b_in[i] = s_axis_tdata[(i+4)*CW +: CW];
            ax = qnlerp_pkg::PROD_W'(a_in[i]);
            bx = qnlerp_pkg::PROD_W'(b_in[i]);
            ab_next[i] = ax * bx;
            pa_next[i] = ax * ox;
            pb_next[i] = bx * tx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            ab_reg <= ab_next;
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

    // ---------------- stage 1: dot product sign ----------------
    logic signed [qnlerp_pkg::PROD_W+1:0] dot;
    logic neg1_reg;
    logic signed [qnlerp_pkg::PROD_W-1:0] pa1_reg [4];
    logic signed [qnlerp_pkg::PROD_W-1:0] pb1_reg [4];

    always_comb
    begin
        dot = '0;
        for (int i = 0; i < 4; i++)
        begin
            dot = dot + (qnlerp_pkg::PROD_W+2)'(ab_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            neg1_reg <= dot[qnlerp_pkg::PROD_W+1];
            pa1_reg <= pa_reg;
            pb1_reg <= pb_reg;
        end
    end

    // ---------------- stage 2: blend ----------------
    logic signed [qnlerp_pkg::BLEND_W-1:0] c_next [4];
    logic signed [qnlerp_pkg::BLEND_W-1:0] c_reg [4];
    logic neg2_reg;

    always_comb
    begin
        logic signed [qnlerp_pkg::BLEND_W-1:0] pbx;
        for (int i = 0; i < 4; i++)
        begin
            pbx = qnlerp_pkg::BLEND_W'(pb1_reg[i]);
            c_next[i] = qnlerp_pkg::BLEND_W'(pa1_reg[i]) + (neg1_reg ? -pbx : pbx);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            c_reg <= c_next;
            neg2_reg <= neg1_reg;
        end
    end

    // ---------------- stage 3: magnitudes ----------------
    logic [qnlerp_pkg::MAG_W-1:0] mg3_reg [4];
    logic [3:0] sg3_reg;
    logic neg3_reg;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            for (int i = 0; i < 4; i++)
            begin
                mg3_reg[i] <= c_reg[i][qnlerp_pkg::BLEND_W-1]
                              ? qnlerp_pkg::MAG_W'(-c_reg[i])
                              : qnlerp_pkg::MAG_W'(c_reg[i]);
                sg3_reg[i] <= c_reg[i][qnlerp_pkg::BLEND_W-1];
            end
            neg3_reg <= neg2_reg;
        end
    end

    // ---------------- stage 4: largest magnitude ----------------
    logic [qnlerp_pkg::MAG_W-1:0] mx01;
    logic [qnlerp_pkg::MAG_W-1:0] mx23;
    logic [qnlerp_pkg::MAG_W-1:0] m4_reg;
    logic [qnlerp_pkg::MAG_W-1:0] mg4_reg [4];
    qnlerp_pkg::meta_t meta4_reg;

    assign mx01 = (mg3_reg[0] > mg3_reg[1]) ? mg3_reg[0] : mg3_reg[1];
    assign mx23 = (mg3_reg[2] > mg3_reg[3]) ? mg3_reg[2] : mg3_reg[3];

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            m4_reg <= (mx01 > mx23) ? mx01 : mx23;
            mg4_reg <= mg3_reg;
            meta4_reg.sg <= sg3_reg;
            meta4_reg.neg <= neg3_reg;
            meta4_reg.zero <= (mx01 == '0) && (mx23 == '0);
        end
    end

    // ---------------- stage 5: shift amount ----------------
    logic [4:0] msb;
    logic rsh5_reg;
    logic [4:0] amt5_reg;
    logic [qnlerp_pkg::MAG_W-1:0] mg5_reg [4];
    qnlerp_pkg::meta_t meta5_reg;

    always_comb
    begin
        msb = '0;
        for (int i = 0; i < qnlerp_pkg::MAG_W; i++)
        begin
            if (m4_reg[i])
            begin
                msb = 5'(i);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[5])
        begin
            rsh5_reg <= msb > 5'(qnlerp_pkg::NORM_TOP);
            amt5_reg <= (msb > 5'(qnlerp_pkg::NORM_TOP)) ? msb - 5'(qnlerp_pkg::NORM_TOP)
                                                         : 5'(qnlerp_pkg::NORM_TOP) - msb;
            mg5_reg <= mg4_reg;
            meta5_reg <= meta4_reg;
        end
    end

    // ---------------- stage 6: normalise ----------------
    qnlerp_pkg::norm_vec_t nm6_reg;
    qnlerp_pkg::meta_t meta6_reg;

    always_ff @(posedge clk)
    begin
        if (adv[6])
        begin
            for (int i = 0; i < 4; i++)
            begin
                nm6_reg[i] <= rsh5_reg ? qnlerp_pkg::NORM_W'(mg5_reg[i] >> amt5_reg)
                                       : qnlerp_pkg::NORM_W'(mg5_reg[i] << amt5_reg);
            end
            meta6_reg <= meta5_reg;
        end
    end

    // ---------------- stage 7: squares ----------------
    logic [qnlerp_pkg::SQ_W-1:0] sq7_reg [4];
    qnlerp_pkg::norm_vec_t nm7_reg;
    qnlerp_pkg::meta_t meta7_reg;

    always_ff @(posedge clk)
    begin
        if (adv[7])
        begin
            for (int i = 0; i < 4; i++)
            begin
                sq7_reg[i] <= qnlerp_pkg::SQ_W'(nm6_reg[i]) * qnlerp_pkg::SQ_W'(nm6_reg[i]);
            end
            nm7_reg <= nm6_reg;
            meta7_reg <= meta6_reg;
        end
    end

    // ---------------- stage 8 onwards: square root, one bit a stage ----------------
    logic [qnlerp_pkg::SUM_W-1:0] isq_n_reg [qnlerp_pkg::ISQ_STEPS+1];
    logic [qnlerp_pkg::ROOT_W-1:0] isq_r_reg [qnlerp_pkg::ISQ_STEPS+1];
    qnlerp_pkg::norm_vec_t isq_nm_reg [qnlerp_pkg::ISQ_STEPS+1];
    qnlerp_pkg::meta_t isq_meta_reg [qnlerp_pkg::ISQ_STEPS+1];

    // Sum of squares seeds the root
    always_ff @(posedge clk)
    begin
        if (adv[qnlerp_pkg::ST_ISQ0])
        begin
            isq_n_reg[0] <= qnlerp_pkg::SUM_W'(sq7_reg[0]) + qnlerp_pkg::SUM_W'(sq7_reg[1])
                          + qnlerp_pkg::SUM_W'(sq7_reg[2]) + qnlerp_pkg::SUM_W'(sq7_reg[3]);
            isq_r_reg[0] <= '0;
            isq_nm_reg[0] <= nm7_reg;
            isq_meta_reg[0] <= meta7_reg;
        end
    end

    for (genvar j = 0; j < qnlerp_pkg::ISQ_STEPS; j++)
    begin : g_isq
        localparam logic [qnlerp_pkg::ROOT_W-1:0] BIT =
            qnlerp_pkg::ROOT_W'(1) << (2 * (qnlerp_pkg::ISQ_STEPS - 1 - j));
        logic [qnlerp_pkg::ROOT_W-1:0] trial;
        logic take;

        assign trial = isq_r_reg[j] + BIT;
        assign take = qnlerp_pkg::ROOT_W'(isq_n_reg[j]) >= trial;

        // Subtract the trial value where it fits and shift the root
        always_ff @(posedge clk)
        begin
            if (adv[qnlerp_pkg::ST_ISQ0+1+j])
            begin
                isq_n_reg[j+1] <= take ? isq_n_reg[j] - qnlerp_pkg::SUM_W'(trial)
                                       : isq_n_reg[j];
                isq_r_reg[j+1] <= take ? (isq_r_reg[j] >> 1) + BIT : isq_r_reg[j] >> 1;
                isq_nm_reg[j+1] <= isq_nm_reg[j];
                isq_meta_reg[j+1] <= isq_meta_reg[j];
            end
        end
    end

    // ---------------- divider, one quotient bit a stage ----------------
    logic [3:0][qnlerp_pkg::NUM_W-1:0] dv_rem_reg [qnlerp_pkg::QBITS+1];
    logic [3:0][qnlerp_pkg::QBITS-1:0] dv_q_reg [qnlerp_pkg::QBITS+1];
    logic [qnlerp_pkg::LEN_W-1:0] dv_len_reg [qnlerp_pkg::QBITS+1];
    qnlerp_pkg::meta_t dv_meta_reg [qnlerp_pkg::QBITS+1];
    logic [qnlerp_pkg::LEN_W-1:0] len_raw;
    logic [qnlerp_pkg::LEN_W-1:0] len_use;

    assign len_raw = qnlerp_pkg::LEN_W'(isq_r_reg[qnlerp_pkg::ISQ_STEPS]);
    assign len_use = (len_raw == '0) ? qnlerp_pkg::LEN_W'(1) : len_raw;

    // Form the rounded numerator
    always_ff @(posedge clk)
    begin
        if (adv[qnlerp_pkg::ST_DIV0])
        begin
            for (int i = 0; i < 4; i++)
            begin
                dv_rem_reg[0][i] <=
                    (qnlerp_pkg::NUM_W'(isq_nm_reg[qnlerp_pkg::ISQ_STEPS][i])
                     << qnlerp_pkg::FRAC_BITS) + qnlerp_pkg::NUM_W'(len_use >> 1);
            end
            dv_q_reg[0] <= '0;
            dv_len_reg[0] <= len_use;
            dv_meta_reg[0] <= isq_meta_reg[qnlerp_pkg::ISQ_STEPS];
        end
    end

    for (genvar s = 0; s < qnlerp_pkg::QBITS; s++)
    begin : g_div
        localparam int QB = qnlerp_pkg::QBITS - 1 - s;
        logic [qnlerp_pkg::NUM_W:0] dsh;
        logic [3:0] take;
        logic [3:0][qnlerp_pkg::QBITS-1:0] qn;

        assign dsh = (qnlerp_pkg::NUM_W+1)'(dv_len_reg[s]) << QB;

        always_comb
        begin
            for (int i = 0; i < 4; i++)
            begin
                take[i] = (qnlerp_pkg::NUM_W+1)'(dv_rem_reg[s][i]) >= dsh;
                qn[i] = dv_q_reg[s][i];
                qn[i][QB] = take[i];
            end
        end

        // Subtract the shifted divisor where it fits and set the quotient bit
        always_ff @(posedge clk)
        begin
            if (adv[qnlerp_pkg::ST_DIV0+1+s])
            begin
                for (int i = 0; i < 4; i++)
                begin
                    dv_rem_reg[s+1][i] <= take[i]
                        ? dv_rem_reg[s][i] - qnlerp_pkg::NUM_W'(dsh)
                        : dv_rem_reg[s][i];
                end
                dv_q_reg[s+1] <= qn;
                dv_len_reg[s+1] <= dv_len_reg[s];
                dv_meta_reg[s+1] <= dv_meta_reg[s];
            end
        end
    end

    // ---------------- output stage: sign, saturate, zero case ----------------
    localparam logic [qnlerp_pkg::QBITS-1:0] POS_LIM = qnlerp_pkg::QBITS'((1 << (CW - 1)) - 1);
    localparam logic [qnlerp_pkg::QBITS-1:0] NEG_LIM = qnlerp_pkg::QBITS'(1 << (CW - 1));

    logic [3:0][CW-1:0] out_next;
    logic [3:0][CW-1:0] out_reg;
    logic flip_reg;
    logic zero_reg;
    qnlerp_pkg::meta_t mfin;

    assign mfin = dv_meta_reg[qnlerp_pkg::QBITS];

    always_comb
    begin
        logic [qnlerp_pkg::QBITS-1:0] q;
        for (int i = 0; i < 4; i++)
        begin
            q = dv_q_reg[qnlerp_pkg::QBITS][i];
            if (mfin.zero)
            begin
                out_next[i] = '0;
            end
            else if (mfin.sg[i])
            begin
                out_next[i] = CW'(-((q > NEG_LIM) ? NEG_LIM : q));
            end
            else
            begin
                out_next[i] = CW'((q > POS_LIM) ? POS_LIM : q);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[qnlerp_pkg::ST_OUT])
        begin
            out_reg <= out_next;
            flip_reg <= mfin.neg;
            zero_reg <= mfin.zero;
        end
    end

    assign m_axis_tvalid = v_reg[N-1];
    assign m_axis_tdata = {8'b0, out_reg};
    assign m_axis_tuser = {zero_reg, flip_reg};

    // ---------------- checks ----------------
`include "quaternion_nlerp_assert.svh"

    `QNL_ASSERT_NOW(a_zero_clears, m_axis_tvalid && m_axis_tuser[1], m_axis_tdata[63:0] == '0)
    `QNL_ASSERT_NOW(a_unit_nonzero, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata[63:0] != '0)
    `QNL_ASSERT_NOW(a_empty_out_ready, !v_reg[N-1], s_axis_tready)

endmodule
